/* design/pfsr_pkg.sv */
// periodic foot swing reference: shared types, register indexes and helpers
// used by the top level and the testbench; no dependencies
package pfsr_pkg;

   typedef enum logic [2:0] {
      REG_HOME   = 3'd0,
      REG_LENGTH = 3'd1,
      REG_HEIGHT = 3'd2,
      REG_START  = 3'd3,
      REG_SWING  = 3'd4,
      REG_STANCE = 3'd5,
      REG_HALF   = 3'd6
   } reg_index_type;

   localparam int unsigned SUM_W = 53;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [23:0]      pos24_type;

   // clamp a wide signed sum to the 24-bit output range
   function automatic pos24_type sat24(input sum_type v);
      sum_type hi;
      sum_type lo;
      hi = sum_type'(24'sh7fffff);
      lo = -sum_type'(24'sh7fffff) - sum_type'(1);
      if (v > hi) begin
         return 24'sh7fffff;
      end else if (v < lo) begin
         return 24'sh800000;
      end else begin
         return v[23:0];
      end
   endfunction

endpackage

/* design/pfsr_div.sv */
// pfsr_div: pipelined unsigned restoring divider, one quotient bit per stage
// with a sideband word that travels alongside; no package dependencies
module pfsr_div #(
   parameter int unsigned NW = 32,
   parameter int unsigned DW = 26,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem,
   output logic [SW-1:0] side_out
);

   logic          v_ff    [NW+1];
   logic [DW-1:0] r_ff    [NW+1];
   logic [NW-1:0] w_ff    [NW+1];
   logic [DW-1:0] d_ff    [NW+1];
   logic [SW-1:0] side_ff [NW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (enable) begin
         v_ff[0] <= in_valid;
      end
      if (enable) begin
         r_ff[0]    <= '0;
         w_ff[0]    <= num;
         d_ff[0]    <= den;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;
      logic [DW-1:0] r_in;
      logic [NW-1:0] w_in;

      // w holds the unused dividend bits on top, quotient bits shift in below
      always_comb begin
         trial = {r_ff[k], w_ff[k][NW-1]};
         ge    = trial >= {1'b0, d_ff[k]};
         diff  = trial - {1'b0, d_ff[k]};
         r_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         w_in  = {w_ff[k][NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (enable) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (enable) begin
            r_ff[k+1]    <= r_in;
            w_ff[k+1]    <= w_in;
            d_ff[k+1]    <= d_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[NW];
   assign quo       = w_ff[NW];
   assign rem       = r_ff[NW];
   assign side_out  = side_ff[NW];

endmodule

/* design/periodic_foot_swing_reference.sv */
// periodic_foot_swing_reference: top level, configuration registers and pipeline
// depends on pfsr_pkg and pfsr_div
//
// Each time sample gives the foot reference x/y/z and a swing flag. One sample
// can be taken every clock while the output is not stalled. The pipeline has
// 90 register stages: a 33-stage divider for the cycle index, then two 51-stage
// dividers in parallel for the x and z fractions, plus six arithmetic stages.
// A stalled output freezes the whole pipeline. Configuration writes are always
// ready and must only happen while no sample is in flight.
module periodic_foot_swing_reference (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_time_now,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [23:0] rsp_pos_z,
   output logic               rsp_swing_active,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data
);

   // configuration
   logic [47:0]        home_ff;
   logic signed [15:0] len_ff;
   logic signed [15:0] hgt_ff;
   logic signed [31:0] start_ff;
   logic [24:0]        swing_ff;
   logic [24:0]        stance_ff;
   logic               half_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         home_ff   <= '0;
         len_ff    <= '0;
         hgt_ff    <= '0;
         start_ff  <= '0;
         swing_ff  <= 25'd1;
         stance_ff <= '0;
         half_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pfsr_pkg::REG_HOME:   home_ff   <= csr_data;
            pfsr_pkg::REG_LENGTH: len_ff    <= csr_data[15:0];
            pfsr_pkg::REG_HEIGHT: hgt_ff    <= csr_data[15:0];
            pfsr_pkg::REG_START:  start_ff  <= csr_data[31:0];
            pfsr_pkg::REG_SWING:  swing_ff  <= csr_data[24:0];
            pfsr_pkg::REG_STANCE: stance_ff <= csr_data[24:0];
            pfsr_pkg::REG_HALF:   half_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [24:0] s_val;
   logic [25:0] p_val;
   assign s_val = (swing_ff == '0) ? 25'd1 : swing_ff;
   assign p_val = {1'b0, s_val} + {1'b0, stance_ff};

   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // stage a: offset from start
   logic               a_v_ff;
   logic signed [32:0] a_d_ff;
   logic signed [32:0] a_d_in;
   assign a_d_in = {req_time_now[31], req_time_now} - {start_ff[31], start_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= req_valid;
      end
      if (advance) begin
         a_d_ff <= a_d_in;
      end
   end

   // cycle index divider: (d - s) / p
   logic        a_cyc;
   logic [32:0] a_n1;
   assign a_cyc = a_d_ff >= $signed({8'd0, s_val});
   assign a_n1  = a_d_ff - $signed({8'd0, s_val});

   logic        d1_v;
   logic [31:0] d1_quo;
   logic [25:0] d1_rem;
   logic [33:0] d1_side;

   pfsr_div #(.NW(32), .DW(26), .SW(34)) u_div_cycle (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (a_v_ff),
      .num      (a_cyc ? a_n1[31:0] : 32'd0),
      .den      (p_val),
      .side_in  ({a_cyc, a_d_ff}),
      .out_valid(d1_v),
      .quo      (d1_quo),
      .rem      (d1_rem),
      .side_out (d1_side)
   );

   // stage c: cycle number and phase within the cycle
   logic               c_v_ff;
   logic [32:0]        c_i_ff;
   logic signed [32:0] c_q_ff;
   logic               c_cyc_ff;
   logic [32:0]        c_i_in;
   logic signed [32:0] c_q_in;

   always_comb begin
      if (d1_side[33]) begin
         c_i_in = {1'b0, d1_quo} + 33'd1;
         c_q_in = {7'd0, d1_rem} + {8'd0, s_val} - {7'd0, p_val};
      end else begin
         c_i_in = '0;
         c_q_in = d1_side[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (advance) begin
         c_v_ff <= d1_v;
      end
      if (advance) begin
         c_i_ff   <= c_i_in;
         c_q_ff   <= c_q_in;
         c_cyc_ff <= d1_side[33];
      end
   end

   // stage d: multiplier operands
   logic               d_v_ff;
   logic signed [34:0] d_xs_ff;
   logic signed [33:0] d_zm_ff;
   logic               d_act_ff;
   logic [32:0]        d_i_ff;
   logic signed [34:0] d_xs_in;
   logic signed [33:0] d_zm_in;
   logic signed [34:0] q35;
   logic signed [34:0] s35;

   always_comb begin
      q35 = {{2{c_q_ff[32]}}, c_q_ff};
      s35 = {10'd0, s_val};
      // half-step mode past the first swing shifts by half a step
      d_xs_in = (half_ff && c_cyc_ff) ? (q35 + q35 - s35) : q35;
      if ((q35 + q35) < s35) begin
         d_zm_in = q35[33:0];
      end else begin
         d_zm_in = s35[33:0] - q35[33:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (advance) begin
         d_v_ff <= c_v_ff;
      end
      if (advance) begin
         d_xs_ff  <= d_xs_in;
         d_zm_ff  <= d_zm_in;
         d_act_ff <= !c_q_ff[32];
         d_i_ff   <= c_i_ff;
      end
   end

   // stage e: products
   logic               e_v_ff;
   logic signed [50:0] e_xp_ff;
   logic signed [49:0] e_zp_ff;
   logic signed [49:0] e_il_ff;
   logic               e_act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (advance) begin
         e_v_ff <= d_v_ff;
      end
      if (advance) begin
         e_xp_ff  <= 51'(d_xs_ff * len_ff);
         e_zp_ff  <= 50'(d_zm_ff * hgt_ff);
         e_il_ff  <= 50'($signed({1'b0, d_i_ff}) * len_ff);
         e_act_ff <= d_act_ff;
      end
   end

   // floor division of signed numerators via one's complement magnitude
   logic               x_neg;
   logic [49:0]        x_mag;
   logic signed [50:0] z_num;
   logic               z_neg;
   logic [49:0]        z_mag;
   logic [25:0]        x_den;

   always_comb begin
      x_neg = e_xp_ff[50];
      x_mag = x_neg ? ~e_xp_ff[49:0] : e_xp_ff[49:0];
      z_num = {e_zp_ff, 1'b0};
      z_neg = z_num[50];
      z_mag = z_neg ? ~z_num[49:0] : z_num[49:0];
      x_den = half_ff ? {s_val, 1'b0} : {1'b0, s_val};
   end

   logic        dx_v;
   logic [49:0] dx_quo;
   logic [25:0] dx_rem;
   logic [51:0] dx_side;
   logic        dz_v;
   logic [49:0] dz_quo;
   logic [24:0] dz_rem;
   logic        dz_side;

   pfsr_div #(.NW(50), .DW(26), .SW(52)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (e_v_ff),
      .num      (x_mag),
      .den      (x_den),
      .side_in  ({x_neg, e_act_ff, e_il_ff}),
      .out_valid(dx_v),
      .quo      (dx_quo),
      .rem      (dx_rem),
      .side_out (dx_side)
   );

   pfsr_div #(.NW(50), .DW(25), .SW(1)) u_div_z (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (e_v_ff),
      .num      (z_mag),
      .den      (s_val),
      .side_in  (z_neg),
      .out_valid(dz_v),
      .quo      (dz_quo),
      .rem      (dz_rem),
      .side_out (dz_side)
   );

   // stage g: sums
   logic                g_v_ff;
   pfsr_pkg::sum_type   g_x_ff;
   pfsr_pkg::sum_type   g_z_ff;
   logic                g_act_ff;
   logic signed [50:0]  dx_val;
   logic signed [50:0]  dz_val;
   pfsr_pkg::sum_type   g_x_in;
   pfsr_pkg::sum_type   g_z_in;
   logic                rem_any;

   always_comb begin
      dx_val = dx_side[51] ? ~$signed({1'b0, dx_quo}) : $signed({1'b0, dx_quo});
      dz_val = dz_side ? ~$signed({1'b0, dz_quo}) : $signed({1'b0, dz_quo});
      g_x_in = pfsr_pkg::sum_type'($signed(home_ff[15:0]))
             + pfsr_pkg::sum_type'($signed(dx_side[49:0]))
             + pfsr_pkg::sum_type'(dx_val);
      g_z_in = pfsr_pkg::sum_type'($signed(home_ff[47:32]))
             + pfsr_pkg::sum_type'(dz_val);
      rem_any = (|dx_rem) | (|dz_rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (advance) begin
         g_v_ff <= dx_v & dz_v & (rem_any | 1'b1);
      end
      if (advance) begin
         g_x_ff   <= g_x_in;
         g_z_ff   <= g_z_in;
         g_act_ff <= dx_side[50];
      end
   end

   // output register
   logic               rsp_valid_ff;
   logic signed [23:0] rsp_x_ff;
   logic signed [15:0] rsp_y_ff;
   logic signed [23:0] rsp_z_ff;
   logic               rsp_act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= g_v_ff;
      end
      if (advance) begin
         rsp_x_ff   <= pfsr_pkg::sat24(g_x_ff);
         rsp_y_ff   <= home_ff[31:16];
         rsp_z_ff   <= pfsr_pkg::sat24(g_z_ff);
         rsp_act_ff <= g_act_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = rsp_x_ff;
   assign rsp_pos_y        = rsp_y_ff;
   assign rsp_pos_z        = rsp_z_ff;
   assign rsp_swing_active = rsp_act_ff;

endmodule

/* verif/tb_periodic_foot_swing_reference.sv */
// testbench for periodic_foot_swing_reference: predicts every sample with an exact
// integer model and scoreboards the result stream; depends on pfsr_pkg and the rtl
module tb_periodic_foot_swing_reference;

   localparam int LATENCY = 90;

   class swing_scoreboard;
      logic [47:0] home;
      longint length, height, start, swing, stance;
      bit half;
      logic [64:0] exp_q[$];
      int errors;
      int mismatches;
      int checked;

      function new();
         home = 0; length = 0; height = 0; start = 0;
         swing = 1; stance = 0; half = 0;
         errors = 0; mismatches = 0; checked = 0;
      endfunction

      function void write_reg(pfsr_pkg::reg_index_type idx, logic [47:0] v);
         case (idx)
            pfsr_pkg::REG_HOME:   home = v;
            pfsr_pkg::REG_LENGTH: length = longint'($signed(v[15:0]));
            pfsr_pkg::REG_HEIGHT: height = longint'($signed(v[15:0]));
            pfsr_pkg::REG_START:  start = longint'($signed(v[31:0]));
            pfsr_pkg::REG_SWING:  swing = longint'({39'd0, v[24:0]});
            pfsr_pkg::REG_STANCE: stance = longint'({39'd0, v[24:0]});
            pfsr_pkg::REG_HALF:   half = v[0];
            default: ;
         endcase
      endfunction

      function longint floor_div(longint n, longint dv);
         longint q;
         q = n / dv;
         if ((n % dv) != 0 && n < 0) q = q - 1;
         return q;
      endfunction

      function logic [23:0] clamp(longint v);
         if (v > 8388607) return 24'h7fffff;
         if (v < -8388608) return 24'h800000;
         return v[23:0];
      endfunction

      // packs x, y, z, active into one word
      function void note_sample(logic signed [31:0] t);
         longint x0, y0, z0, s, p, d, q, dx, dz, i;
         bit act;
         x0 = longint'($signed(home[15:0]));
         y0 = longint'($signed(home[31:16]));
         z0 = longint'($signed(home[47:32]));
         s = (swing > 0) ? swing : 1;
         p = s + stance;
         d = longint'(t) - start;
         if (d < s) begin
            q = d;
            dx = half ? floor_div(d * length, 2 * s) : floor_div(d * length, s);
         end else begin
            i = floor_div(d - s, p) + 1;
            q = d - i * p;
            dx = half ? floor_div((2 * i * s - s + 2 * q) * length, 2 * s)
                      : floor_div((i * s + q) * length, s);
         end
         if (2 * q < s) dz = floor_div(2 * q * height, s);
         else dz = floor_div(2 * (s - q) * height, s);
         act = (d >= 0) && ((d - floor_div(d, p) * p) < s);
         exp_q.push_back({clamp(x0 + dx), y0[15:0], clamp(z0 + dz), act});
      endfunction

      function void check_result(logic [23:0] x, logic [15:0] y, logic [23:0] z, logic a);
         logic [64:0] e;
         checked++;
         if (exp_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result x=%h y=%h z=%h a=%b", x, y, z, a);
            return;
         end
         e = exp_q.pop_front();
         if (e !== {x, y, z, a}) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp x=%h y=%h z=%h a=%b got x=%h y=%h z=%h a=%b",
                        e[64:41], e[40:25], e[24:1], e[0], x, y, z, a);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_time_now = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [23:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic signed [23:0] rsp_pos_z;
   logic rsp_swing_active;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [47:0] csr_data = 0;

   swing_scoreboard sb = new();
   bit long_hold = 0;
   bit hold_done = 0;

   always #5 clock = ~clock;

   periodic_foot_swing_reference u_top (.*);

   // receiver: own stall pattern plus one long hold-off
   initial begin : receiver
      int n;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_done = 1;
            rsp_stall <= 0;
         end else begin
            n = $urandom_range(0, 99);
            rsp_stall <= (n < 25) || (n < 60 && rsp_stall);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_swing_active);

   task automatic write_csr(pfsr_pkg::reg_index_type idx, logic [47:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_sample(logic signed [31:0] t);
      req_valid <= 1;
      req_time_now <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(t);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.exp_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic signed [31:0] near_time(longint base, longint span);
      longint v;
      v = base + longint'($signed($urandom_range(0, 2 * 32'(span)))) - span;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   task automatic random_config(int phase);
      logic [47:0] h;
      h = 48'({$urandom(), $urandom()});
      if (phase % 3 == 0) h = {16'h7fff, 16'h8000, 16'h7fff};
      write_csr(pfsr_pkg::REG_HOME, h);
      write_csr(pfsr_pkg::REG_LENGTH,
                (phase % 4 == 1) ? 48'h8000 : {16'd0, $urandom()});
      write_csr(pfsr_pkg::REG_HEIGHT,
                (phase % 4 == 2) ? 48'h7fff : {16'd0, $urandom()});
      write_csr(pfsr_pkg::REG_START, {16'd0, $urandom()});
      case (phase % 5)
         0: write_csr(pfsr_pkg::REG_SWING, 48'd1);
         1: write_csr(pfsr_pkg::REG_SWING, 48'h1000000);
         2: write_csr(pfsr_pkg::REG_SWING, 48'd0);
         default: write_csr(pfsr_pkg::REG_SWING, 48'($urandom_range(1, 5000)));
      endcase
      case (phase % 4)
         0: write_csr(pfsr_pkg::REG_STANCE, 48'd0);
         1: write_csr(pfsr_pkg::REG_STANCE, 48'h1000000);
         default: write_csr(pfsr_pkg::REG_STANCE, 48'($urandom_range(0, 5000)));
      endcase
      write_csr(pfsr_pkg::REG_HALF, 48'($urandom_range(0, 1)));
      // index beyond the register map must be ignored
      csr_valid <= 1;
      csr_index <= 3'd7;
      csr_data <= 48'({$urandom(), $urandom()});
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   initial begin : stimulus
      longint per;
      int bursts, k;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset settings then extremes
      send_sample(32'sh7fffffff);
      send_sample(32'sh80000000);
      send_sample(0);
      drain();
      write_csr(pfsr_pkg::REG_HOME, {16'h7fff, 16'h8000, 16'h8000});
      write_csr(pfsr_pkg::REG_LENGTH, 48'h7fff);
      write_csr(pfsr_pkg::REG_HEIGHT, 48'h8000);
      write_csr(pfsr_pkg::REG_START, 48'd1000);
      write_csr(pfsr_pkg::REG_SWING, 48'd100);
      write_csr(pfsr_pkg::REG_STANCE, 48'd50);
      write_csr(pfsr_pkg::REG_HALF, 48'd1);
      for (k = 0; k < 20; k++) send_sample(900 + k * 23);
      send_sample(32'sh7fffffff);
      send_sample(32'sh80000000);
      drain();
      for (int phase = 0; phase < 10; phase++) begin
         random_config(phase);
         per = sb.swing + sb.stance;
         if (phase == 3) long_hold = 1;
         for (int n = 0; n < 185; ) begin
            bursts = $urandom_range(1, 20);
            for (k = 0; k < bursts && n < 185; k++, n++) begin
               if ($urandom_range(0, 9) == 0) send_sample($urandom());
               else send_sample(near_time(sb.start, 4 * per + 10));
            end
            if ($urandom_range(0, 2) != 0) begin
               req_valid <= 0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
         drain();
      end
      $display("covered 10 register settings, signed time extremes, zero swing, long hold-off");
      $display("checked %0d results, %0d failures", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.exp_q.size() == 0) begin
         $display("tb_periodic_foot_swing_reference: PASS");
      end else begin
         $display("tb_periodic_foot_swing_reference: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("tb_periodic_foot_swing_reference: FAIL");
      $finish;
   end
endmodule
